@@ src/guest_agent_keepalive_responder_assert.svh @@
// ----------------------------------------------------------------------------
// Keepalive responder assertion macros
// Concurrent assertion wrappers, clocked on i_clk. Defining ASSERT_OFF
// compiles them away.
// ----------------------------------------------------------------------------
`ifndef GUEST_AGENT_KEEPALIVE_RESPONDER_ASSERT_SVH
`define GUEST_AGENT_KEEPALIVE_RESPONDER_ASSERT_SVH
`ifndef ASSERT_OFF
// assertion that is ignored while reset is held
`define GAKR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");
// assertion that holds during reset too
`define GAKR_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("assertion failed");
`else
`define GAKR_ASSERT(lbl, prop)
`define GAKR_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ src/gakr_pkg.sv @@
// ----------------------------------------------------------------------------
// Keepalive responder package
// Character constants, match strings, reply job type and state codes.
// ----------------------------------------------------------------------------
package gakr_pkg;

    localparam logic [7:0] ChNewline = 8'h0A;
    localparam logic [7:0] ChTab     = 8'h09;
    localparam logic [7:0] ChSpace   = 8'h20;
    localparam logic [7:0] ChQuote   = 8'h22;
    localparam logic [7:0] ChZero    = 8'h30;
    localparam logic [7:0] ChNine    = 8'h39;
    localparam logic [7:0] ChColon   = 8'h3A;
    localparam logic [7:0] ChLowerD  = 8'h64;
    localparam logic [7:0] ChLowerI  = 8'h69;
    localparam logic [7:0] ChOpen    = 8'h7B;
    localparam logic [7:0] ChClose   = 8'h7D;
    localparam logic [7:0] ChMark    = 8'hFF;

    // last 20 line bytes, newest in the low byte
    localparam logic [159:0] DelimTxt = "guest-sync-delimited";

    localparam logic [2:0] NeedleLen = 3'd5;

    // id parse phases
    typedef enum logic [4:0] {
        PH_SEARCH = 5'b00001,
        PH_SKIP   = 5'b00010,
        PH_DIGITS = 5'b00100,
        PH_FOUND  = 5'b01000,
        PH_FAILED = 5'b10000
    } t_phase;

    // one reply to be generated
    typedef struct packed {
        logic        mark;
        logic        has_id;
        logic [63:0] id;
        logic [2:0]  port;
    } t_job;

    // byte k of "id":
    function automatic logic [7:0] needle_byte(input logic [2:0] k);
        logic [7:0] r;
        case (k)
            3'd0:    r = ChQuote;
            3'd1:    r = ChLowerI;
            3'd2:    r = ChLowerD;
            3'd3:    r = ChQuote;
            3'd4:    r = ChColon;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // byte k of {"return":
    function automatic logic [7:0] prefix_byte(input logic [3:0] k);
        logic [7:0] r;
        case (k)
            4'd0:    r = ChOpen;
            4'd1:    r = ChQuote;
            4'd2:    r = 8'h72;
            4'd3:    r = 8'h65;
            4'd4:    r = 8'h74;
            4'd5:    r = 8'h75;
            4'd6:    r = 8'h72;
            4'd7:    r = 8'h6E;
            4'd8:    r = ChQuote;
            4'd9:    r = ChColon;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

@@ src/gakr_if.sv @@
// ----------------------------------------------------------------------------
// Keepalive responder channel interfaces
// Valid/ready channels for received bytes and reply bytes.
// ----------------------------------------------------------------------------
interface gakr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;
    logic [2:0] port_number;

    modport source (output valid, data_byte, end_of_buffer, port_number, input ready);
    modport sink   (input valid, data_byte, end_of_buffer, port_number, output ready);
endinterface

interface gakr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] reply_byte;
    logic [2:0] reply_port;
    logic       reply_last;

    modport source (output valid, reply_byte, reply_port, reply_last, input ready);
    modport sink   (input valid, reply_byte, reply_port, reply_last, output ready);
endinterface

@@ src/gakr_front.sv @@
// ----------------------------------------------------------------------------
// Keepalive responder front end
// Takes received bytes, tracks lines, parses the id and spots the delimiter
// request; queues one reply job per closed non-empty line.
// ----------------------------------------------------------------------------
module gakr_front #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    gakr_in_if.sink        i_in,
    input  logic           i_full,
    output logic           o_push,
    output gakr_pkg::t_job o_job
);
    localparam int CW = $clog2(BUFFER_BYTES + 1);

    logic [CW-1:0]     r_cnt, n_cnt;
    gakr_pkg::t_phase  r_phase, s_phase;
    logic [2:0]        r_prog, s_prog;
    logic [63:0]       r_val, s_val;
    logic [159:0]      r_win, s_win;
    logic              r_seen, s_seen;
    logic              r_conf, s_conf;
    logic              r_lhb, s_lhb;

    logic       accept, counted, nl, blank, digit, close;
    logic [7:0] b;
    logic [63:0] dig64;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && i_in.ready;
    assign b          = i_in.data_byte;
    assign counted    = r_cnt < CW'(BUFFER_BYTES);
    assign nl         = b == gakr_pkg::ChNewline;
    assign blank      = (b == gakr_pkg::ChSpace) || (b == gakr_pkg::ChTab);
    assign digit      = (b >= gakr_pkg::ChZero) && (b <= gakr_pkg::ChNine);
    assign dig64      = {60'd0, b[3:0]};

    // line state after this byte is fed
    always_comb begin
        s_phase = r_phase;
        s_prog  = r_prog;
        s_val   = r_val;
        s_win   = r_win;
        s_seen  = r_seen;
        s_conf  = r_conf;
        s_lhb   = r_lhb;
        if (counted && !nl) begin
            s_lhb = 1'b1;
            case (r_phase)
                gakr_pkg::PH_SEARCH: begin
                    if (r_prog < gakr_pkg::NeedleLen && b == gakr_pkg::needle_byte(r_prog)) begin
                        s_prog = r_prog + 3'd1;
                        if (r_prog == 3'd4) s_phase = gakr_pkg::PH_SKIP;
                    end else if (r_prog == 3'd4 && b == gakr_pkg::ChLowerI) begin
                        s_prog = 3'd2;
                    end else begin
                        s_prog = (b == gakr_pkg::ChQuote) ? 3'd1 : 3'd0;
                    end
                end
                gakr_pkg::PH_SKIP: begin
                    if (digit) begin
                        s_val   = dig64;
                        s_phase = gakr_pkg::PH_DIGITS;
                    end else if (!blank) begin
                        s_phase = gakr_pkg::PH_FAILED;
                    end
                end
                gakr_pkg::PH_DIGITS: begin
                    if (digit) s_val = {r_val[60:0], 3'd0} + {r_val[62:0], 1'b0} + dig64;
                    else       s_phase = gakr_pkg::PH_FOUND;
                end
                default: ;
            endcase
            if (r_seen) s_conf = 1'b1;
            s_win  = {r_win[151:0], b};
            s_seen = s_win == gakr_pkg::DelimTxt;
        end
    end

    // line closes at a counted newline or at the end of a buffer
    assign close  = (counted && nl) || i_in.end_of_buffer;
    assign o_push = accept && close && s_lhb;
    assign o_job  = '{mark:   s_conf,
                      has_id: (s_phase == gakr_pkg::PH_FOUND) || (s_phase == gakr_pkg::PH_DIGITS),
                      id:     s_val,
                      port:   i_in.port_number};

    always_comb begin
        n_cnt = r_cnt;
        if (i_in.end_of_buffer) n_cnt = '0;
        else if (counted)       n_cnt = r_cnt + CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_phase <= gakr_pkg::PH_SEARCH;
            r_prog  <= '0;
            r_val   <= '0;
            r_win   <= '0;
            r_seen  <= 1'b0;
            r_conf  <= 1'b0;
            r_lhb   <= 1'b0;
        end else if (accept) begin
            r_cnt <= n_cnt;
            if (close) begin
                r_phase <= gakr_pkg::PH_SEARCH;
                r_prog  <= '0;
                r_val   <= '0;
                r_win   <= '0;
                r_seen  <= 1'b0;
                r_conf  <= 1'b0;
                r_lhb   <= 1'b0;
            end else begin
                r_phase <= s_phase;
                r_prog  <= s_prog;
                r_val   <= s_val;
                r_win   <= s_win;
                r_seen  <= s_seen;
                r_conf  <= s_conf;
                r_lhb   <= s_lhb;
            end
        end
    end

endmodule

@@ src/gakr_queue.sv @@
// ----------------------------------------------------------------------------
// Keepalive responder job queue
// Two-entry queue of reply jobs between front and back end.
// ----------------------------------------------------------------------------
`include "guest_agent_keepalive_responder_assert.svh"

module gakr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gakr_pkg::t_job i_job,
    input  logic           i_pop,
    output gakr_pkg::t_job o_job,
    output logic           o_full,
    output logic           o_empty
);
    gakr_pkg::t_job r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_count;

    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;
    assign o_job   = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    `GAKR_ASSERT(a_no_overflow, i_push |-> !o_full)
    `GAKR_ASSERT(a_no_underflow, i_pop |-> !o_empty)
    `GAKR_ASSERT(a_count_range, r_count != 2'd3)

endmodule

@@ src/gakr_back.sv @@
// ----------------------------------------------------------------------------
// Keepalive responder back end
// Turns a reply job into bytes: optional mark, prefix, decimal id or empty
// object, closing brace, newline. Binary to decimal by shift-add-3.
// ----------------------------------------------------------------------------
`include "guest_agent_keepalive_responder_assert.svh"

module gakr_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  gakr_pkg::t_job i_job,
    output logic           o_pop,
    gakr_out_if.source     o_out
);
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CONV   = 7'b0000010,
        S_MARK   = 7'b0000100,
        S_PREFIX = 7'b0001000,
        S_BODY   = 7'b0010000,
        S_CLOSE  = 7'b0100000,
        S_NL     = 7'b1000000
    } t_state;

    t_state         r_state, n_state;
    gakr_pkg::t_job r_job, n_job;
    logic [63:0]    r_bin, n_bin;
    logic [79:0]    r_bcd, n_bcd;
    logic [5:0]     r_idx, n_idx;
    logic           r_lead, n_lead;
    logic           r_ov;
    logic [7:0]     r_ob;
    logic           r_ol;
    logic [2:0]     r_op;

    logic       take, emit, emit_last;
    logic [7:0] emit_byte;
    logic [3:0] dig;
    logic [79:0] dab;

    // add 3 to every digit of 5 or more
    function automatic logic [79:0] dabble(input logic [79:0] v);
        logic [79:0] r;
        r = v;
        for (int k = 0; k < 20; k++) begin
            if (v[k*4 +: 4] >= 4'd5) r[k*4 +: 4] = v[k*4 +: 4] + 4'd3;
        end
        return r;
    endfunction

    assign take = !r_ov || o_out.ready;
    assign dig  = r_bcd[79:76];
    assign dab  = dabble(r_bcd);

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_job     = r_job;
        n_bin     = r_bin;
        n_bcd     = r_bcd;
        n_idx     = r_idx;
        n_lead    = r_lead;
        o_pop     = 1'b0;
        emit      = 1'b0;
        emit_last = 1'b0;
        emit_byte = gakr_pkg::ChNewline;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_job   = i_job;
                    n_bin   = i_job.id;
                    n_bcd   = '0;
                    n_idx   = '0;
                    n_state = i_job.has_id ? S_CONV : (i_job.mark ? S_MARK : S_PREFIX);
                end
            end
            S_CONV: begin
                n_bcd = {dab[78:0], r_bin[63]};
                n_bin = {r_bin[62:0], 1'b0};
                n_idx = r_idx + 6'd1;
                if (r_idx == 6'd63) begin
                    n_idx   = '0;
                    n_state = r_job.mark ? S_MARK : S_PREFIX;
                end
            end
            S_MARK: begin
                if (take) begin
                    emit      = 1'b1;
                    emit_byte = gakr_pkg::ChMark;
                    n_idx     = '0;
                    n_state   = S_PREFIX;
                end
            end
            S_PREFIX: begin
                if (take) begin
                    emit      = 1'b1;
                    emit_byte = gakr_pkg::prefix_byte(r_idx[3:0]);
                    if (r_idx == 6'd9) begin
                        n_idx   = r_job.has_id ? 6'd19 : 6'd0;
                        n_lead  = 1'b1;
                        n_state = S_BODY;
                    end else begin
                        n_idx = r_idx + 6'd1;
                    end
                end
            end
            S_BODY: begin
                if (r_job.has_id) begin
                    // leading zeros are dropped, the last digit always goes out
                    if (r_lead && dig == 4'd0 && r_idx != 6'd0) begin
                        n_bcd = {r_bcd[75:0], 4'd0};
                        n_idx = r_idx - 6'd1;
                    end else if (take) begin
                        emit      = 1'b1;
                        emit_byte = gakr_pkg::ChZero | {4'd0, dig};
                        n_lead    = 1'b0;
                        n_bcd     = {r_bcd[75:0], 4'd0};
                        if (r_idx == 6'd0) n_state = S_CLOSE;
                        else               n_idx   = r_idx - 6'd1;
                    end
                end else if (take) begin
                    // empty object
                    emit      = 1'b1;
                    emit_byte = (r_idx == 6'd0) ? gakr_pkg::ChOpen : gakr_pkg::ChClose;
                    if (r_idx == 6'd1) n_state = S_CLOSE;
                    else               n_idx   = r_idx + 6'd1;
                end
            end
            S_CLOSE: begin
                if (take) begin
                    emit      = 1'b1;
                    emit_byte = gakr_pkg::ChClose;
                    n_state   = S_NL;
                end
            end
            S_NL: begin
                if (take) begin
                    emit      = 1'b1;
                    emit_last = 1'b1;
                    emit_byte = gakr_pkg::ChNewline;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (take) r_ov <= emit;
        end
    end

    // payload registers; port is held with its byte while the next job loads
    always_ff @(posedge i_clk) begin
        r_job  <= n_job;
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_idx  <= n_idx;
        r_lead <= n_lead;
        if (take && emit) begin
            r_ob <= emit_byte;
            r_ol <= emit_last;
            r_op <= r_job.port;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.reply_byte = r_ob;
    assign o_out.reply_port = r_op;
    assign o_out.reply_last = r_ol;

    `GAKR_ASSERT(a_last_is_newline, (r_ov && r_ol) |-> (r_ob == gakr_pkg::ChNewline))
    `GAKR_ASSERT(a_pop_only_idle, o_pop |-> (r_state == S_IDLE))
    `GAKR_ASSERT(a_new_job_after_last, (o_pop && r_ov) |-> r_ol)

endmodule

@@ src/guest_agent_keepalive_responder.sv @@
// ----------------------------------------------------------------------------
// Guest agent keepalive responder
// Splits received bytes into lines and answers each non-empty line with a
// return reply carrying the parsed id.
//
//   channel  dir  transaction
//   i_in     in   one received byte, end-of-buffer mark, port
//   o_out    out  one reply byte, port, last-of-reply mark
//
// Input bytes are taken one per cycle while the two-entry job queue has room.
// A reply is popped, its id converted binary-to-decimal when present, then
// leading zero digits are skipped and the reply bytes go out one by one.
// The input stalls only when two replies are pending behind the one in work.
// Synchronous active-low reset clears line state and all handshakes.
// ----------------------------------------------------------------------------
module guest_agent_keepalive_responder #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gakr_in_if.sink     i_in,
    gakr_out_if.source  o_out
);
    logic           push, pop, full, empty;
    gakr_pkg::t_job job_in, job_out;

    gakr_front #(.BUFFER_BYTES(BUFFER_BYTES)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_job   (job_in)
    );

    gakr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_full  (full),
        .o_empty (empty)
    );

    gakr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (job_out),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
